>>> sv/irar_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irar_pkg
// Shared types, constants and weight tables of the integer-ratio resampler.
// ---------------------------------------------------------------------------
package irar_pkg;

	localparam int SMP_W          = 16;
	localparam int CNT_W          = 4;
	localparam int SCALE_W        = 4;
	localparam int CHCNT_W        = 2;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 4;
	// widest down-mode sum: 15 samples of 16 bits
	localparam int SUM_W          = 20;
	localparam int DIV_W          = SUM_W;
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_ITERS      = DIV_W / DIV_RADIX_BITS;
	localparam int WGT_W          = 7;
	localparam int STEP_W         = 4;
	localparam int SHIFT_W        = 3;
	localparam int PROD_W         = 24;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [SCALE_W-1:0] MIN_SCALE    = 4'd2;
	localparam logic [SCALE_W-1:0] UP_MAX_SCALE = 4'd6;
	localparam logic [SCALE_W-1:0] SCALE_LIMIT  = 4'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION = 2'd0,
		REG_SCALE     = 2'd1,
		REG_CHANNELS  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_UP   = 1'b0,
		MODE_DOWN = 1'b1
	} mode_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_in;
		logic                    channel_in;
	} in_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    channel_out;
		logic                    last_of_run;
	} out_item_t;

	// work handed from the front end to the back end
	typedef struct packed {
		mode_t                   kind;
		logic                    ch;
		logic [SCALE_W-1:0]      n;
		logic signed [SMP_W-1:0] prev;
		logic signed [SMP_W-1:0] cur;
		logic signed [SUM_W-1:0] sum;
	} cmd_t;

	typedef struct packed {
		mode_t                    kind;
		logic                     ch;
		logic                     last;
		logic signed [PROD_W-1:0] p_prev;
		logic signed [PROD_W-1:0] p_cur;
		logic [SHIFT_W-1:0]       shift;
		logic [DIV_W-1:0]         quo;
		logic                     neg;
	} s1_t;

	// weight increment per result, by row (row = n - 2)
	function automatic logic [STEP_W-1:0] weight_step(input logic [SHIFT_W-1:0] row);
		logic [STEP_W-1:0] s;
		case (row)
			3'd0:    s = 4'd1;
			3'd1:    s = 4'd5;
			3'd2:    s = 4'd1;
			3'd3:    s = 4'd6;
			3'd4:    s = 4'd11;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	// log2 of the divisor, by row
	function automatic logic [SHIFT_W-1:0] frac_shift(input logic [SHIFT_W-1:0] row);
		logic [SHIFT_W-1:0] s;
		case (row)
			3'd0:    s = 3'd1;
			3'd1:    s = 3'd4;
			3'd2:    s = 3'd2;
			3'd3:    s = 3'd5;
			3'd4:    s = 3'd6;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

>>> sv/irar_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irar_front
// Config registers, per-channel state and classification of input beats.
// ---------------------------------------------------------------------------
module irar_front #(
	parameter int MAX_CHANNELS   = 2,
	parameter int MAX_DOWN_SCALE = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [irar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [irar_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  irar_pkg::in_item_t                  src_data,
	input  logic                                q_full,
	output logic                                q_push,
	output irar_pkg::cmd_t                      q_push_data
);

	localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DOWN_CAP = (MAX_DOWN_SCALE > 15) ? 15 : MAX_DOWN_SCALE;
	localparam int LSUM_W   = irar_pkg::SMP_W + $clog2(DOWN_CAP);
	localparam logic [irar_pkg::SCALE_W-1:0] DCAP  = irar_pkg::SCALE_W'(DOWN_CAP);
	localparam logic [irar_pkg::SCALE_W-1:0] MAXCH = irar_pkg::SCALE_W'(MAX_CHANNELS);

	irar_pkg::mode_t                     direction_q;
	logic [irar_pkg::SCALE_W-1:0]        scale_q;
	logic [irar_pkg::CHCNT_W-1:0]        chcnt_q;

	logic signed [irar_pkg::SMP_W-1:0]   prev_q [MAX_CHANNELS];
	logic signed [LSUM_W-1:0]            sum_q  [MAX_CHANNELS];
	logic [irar_pkg::CNT_W-1:0]          cnt_q  [MAX_CHANNELS];

	logic [CH_IDX_W-1:0]                 idx;
	logic [irar_pkg::SCALE_W-1:0]        nch;
	logic                                ch_ok;
	logic                                accept;
	logic [irar_pkg::SCALE_W-1:0]        scale_lo;
	logic [irar_pkg::SCALE_W-1:0]        n_up;
	logic [irar_pkg::SCALE_W-1:0]        n_down;
	logic signed [LSUM_W-1:0]            sum_new;
	logic [irar_pkg::CNT_W-1:0]          cnt_new;
	logic                                emit;

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;
	assign idx       = CH_IDX_W'(src_data.channel_in);

	always_comb begin
		if (chcnt_q == '0)
			nch = irar_pkg::SCALE_W'(1);
		else if (irar_pkg::SCALE_W'(chcnt_q) > MAXCH)
			nch = MAXCH;
		else
			nch = irar_pkg::SCALE_W'(chcnt_q);
	end

	assign ch_ok    = irar_pkg::SCALE_W'(src_data.channel_in) < nch;
	assign scale_lo = (scale_q < irar_pkg::MIN_SCALE) ? irar_pkg::MIN_SCALE : scale_q;
	assign n_up     = (scale_lo > irar_pkg::UP_MAX_SCALE) ? irar_pkg::UP_MAX_SCALE : scale_lo;
	assign n_down   = (scale_lo > DCAP) ? DCAP : scale_lo;

	assign sum_new  = sum_q[idx] + LSUM_W'(src_data.sample_in);
	assign cnt_new  = cnt_q[idx] + irar_pkg::CNT_W'(1);
	assign emit     = cnt_new >= n_down;

	assign q_push = accept && ch_ok && ((direction_q == irar_pkg::MODE_UP) || emit);

	always_comb begin
		q_push_data.kind = direction_q;
		q_push_data.ch   = src_data.channel_in;
		q_push_data.n    = (direction_q == irar_pkg::MODE_UP) ? n_up : n_down;
		q_push_data.prev = prev_q[idx];
		q_push_data.cur  = src_data.sample_in;
		q_push_data.sum  = irar_pkg::SUM_W'(sum_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= irar_pkg::MODE_UP;
			scale_q     <= irar_pkg::MIN_SCALE;
			chcnt_q     <= irar_pkg::CHCNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				irar_pkg::REG_DIRECTION: direction_q <= irar_pkg::mode_t'(cfg_data[0]);
				irar_pkg::REG_SCALE:     scale_q     <= cfg_data;
				irar_pkg::REG_CHANNELS:  chcnt_q     <= cfg_data[irar_pkg::CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_q[i] <= '0;
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (accept && ch_ok) begin
			if (direction_q == irar_pkg::MODE_UP) begin
				prev_q[idx] <= src_data.sample_in;
			end else if (emit) begin
				sum_q[idx] <= '0;
				cnt_q[idx] <= '0;
			end else begin
				sum_q[idx] <= sum_new;
				cnt_q[idx] <= cnt_new;
			end
		end
	end

endmodule

>>> sv/irar_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irar_queue
// Two-entry command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module irar_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  irar_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            avail,
	output irar_pkg::cmd_t  pop_data
);

	localparam int PTR_W = $clog2(irar_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(irar_pkg::QUEUE_DEPTH + 1);

	irar_pkg::cmd_t      mem_q [irar_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full     = count_q == CNT_W'(irar_pkg::QUEUE_DEPTH);
	assign avail    = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> sv/irar_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irar_back
// Executes commands: interpolation beats in up mode, radix-16 divide in down
// mode, followed by a rounding/saturation stage and the output register.
// ---------------------------------------------------------------------------
module irar_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_avail,
	input  irar_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output irar_pkg::out_item_t  dst_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UP   = 3'b010,
		ST_DIV  = 3'b100
	} back_state_t;

	localparam int ITER_W = $clog2(irar_pkg::DIV_ITERS + 1);
	localparam logic signed [irar_pkg::PROD_W-1:0] SAT_HI = irar_pkg::PROD_W'(32767);
	localparam logic signed [irar_pkg::PROD_W-1:0] SAT_LO = -irar_pkg::PROD_W'(32768);

	back_state_t                           state_q;
	irar_pkg::cmd_t                        cmd_q;
	logic [irar_pkg::SHIFT_W-1:0]          k_q;
	logic [ITER_W-1:0]                     iter_q;
	logic [irar_pkg::WGT_W-1:0]            wp_q;
	logic [irar_pkg::WGT_W-1:0]            wc_q;
	logic [irar_pkg::STEP_W-1:0]           step_q;
	logic [irar_pkg::SHIFT_W-1:0]          shift_q;
	logic [irar_pkg::DIV_W-1:0]            dvd_q;
	logic [irar_pkg::SCALE_W-1:0]          rem_q;
	logic                                  neg_q;

	irar_pkg::s1_t                         s1_s1;
	logic                                  valid_s1;
	irar_pkg::out_item_t                   out_q;
	logic                                  out_valid_q;

	logic                                  advance;
	logic                                  last_up;
	logic                                  div_done;
	logic                                  issue;
	logic [irar_pkg::SHIFT_W-1:0]          row;

	logic [irar_pkg::SCALE_W:0]            div_t;
	logic [irar_pkg::SCALE_W-1:0]          div_r;
	logic [irar_pkg::DIV_W-1:0]            div_d;

	logic signed [irar_pkg::PROD_W-1:0]    acc2;
	logic signed [irar_pkg::PROD_W-1:0]    bias2;
	logic signed [irar_pkg::PROD_W-1:0]    pre_sat;
	logic signed [irar_pkg::SMP_W-1:0]     sat_val;

	assign advance  = !out_valid_q || !dst_stall;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_avail;
	assign last_up  = irar_pkg::SCALE_W'(k_q) == (cmd_q.n - irar_pkg::SCALE_W'(1));
	assign div_done = iter_q == ITER_W'(irar_pkg::DIV_ITERS);
	assign issue    = (state_q == ST_UP) || ((state_q == ST_DIV) && div_done);
	assign row      = irar_pkg::SHIFT_W'(cmd.n - irar_pkg::MIN_SCALE);

	// four restoring quotient bits per cycle
	always_comb begin
		div_r = rem_q;
		div_d = dvd_q;
		div_t = '0;
		for (int i = 0; i < irar_pkg::DIV_RADIX_BITS; i++) begin
			div_t = {div_r, div_d[irar_pkg::DIV_W-1]};
			div_d = {div_d[irar_pkg::DIV_W-2:0], 1'b0};
			if (div_t >= {1'b0, cmd_q.n}) begin
				div_t    = div_t - {1'b0, cmd_q.n};
				div_d[0] = 1'b1;
			end
			div_r = div_t[irar_pkg::SCALE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			iter_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_avail) begin
						state_q <= (cmd.kind == irar_pkg::MODE_UP) ? ST_UP : ST_DIV;
						k_q     <= '0;
						iter_q  <= '0;
					end
				end
				ST_UP: begin
					if (advance) begin
						k_q <= k_q + irar_pkg::SHIFT_W'(1);
						if (last_up)
							state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (!div_done)
						iter_q <= iter_q + ITER_W'(1);
					else if (advance)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (advance) begin
				valid_s1    <= issue;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q   <= cmd;
			step_q  <= irar_pkg::weight_step(row);
			shift_q <= irar_pkg::frac_shift(row);
			wc_q    <= irar_pkg::WGT_W'(irar_pkg::weight_step(row));
			wp_q    <= irar_pkg::WGT_W'(irar_pkg::WGT_W'(irar_pkg::weight_step(row))
				* irar_pkg::WGT_W'(cmd.n - irar_pkg::SCALE_W'(1)));
			rem_q   <= '0;
			neg_q   <= cmd.sum[irar_pkg::SUM_W-1];
			dvd_q   <= cmd.sum[irar_pkg::SUM_W-1] ? irar_pkg::DIV_W'(-cmd.sum)
				: irar_pkg::DIV_W'(cmd.sum);
		end else if ((state_q == ST_UP) && advance) begin
			wp_q <= wp_q - irar_pkg::WGT_W'(step_q);
			wc_q <= wc_q + irar_pkg::WGT_W'(step_q);
		end else if ((state_q == ST_DIV) && !div_done) begin
			dvd_q <= div_d;
			rem_q <= div_r;
		end

		if (advance && issue) begin
			s1_s1.kind   <= cmd_q.kind;
			s1_s1.ch     <= cmd_q.ch;
			s1_s1.last   <= (state_q == ST_DIV) || last_up;
			s1_s1.p_prev <= $signed({1'b0, wp_q}) * cmd_q.prev;
			s1_s1.p_cur  <= $signed({1'b0, wc_q}) * cmd_q.cur;
			s1_s1.shift  <= shift_q;
			s1_s1.quo    <= dvd_q;
			s1_s1.neg    <= neg_q;
		end

		if (advance && valid_s1) begin
			out_q.sample_out  <= sat_val;
			out_q.channel_out <= s1_s1.ch;
			out_q.last_of_run <= s1_s1.last;
		end
	end

	// up mode: divide by 2^shift truncating toward zero; down mode: signed quotient; then clamp to 16 bits
	always_comb begin
		acc2  = s1_s1.p_prev + s1_s1.p_cur;
		bias2 = acc2[irar_pkg::PROD_W-1]
			? $signed((irar_pkg::PROD_W'(1) << s1_s1.shift) - irar_pkg::PROD_W'(1))
			: '0;
		if (s1_s1.kind == irar_pkg::MODE_UP)
			pre_sat = (acc2 + bias2) >>> s1_s1.shift;
		else if (s1_s1.neg)
			pre_sat = -$signed(irar_pkg::PROD_W'(s1_s1.quo));
		else
			pre_sat = $signed(irar_pkg::PROD_W'(s1_s1.quo));
		if (pre_sat > SAT_HI)
			sat_val = irar_pkg::SMP_W'(SAT_HI);
		else if (pre_sat < SAT_LO)
			sat_val = irar_pkg::SMP_W'(SAT_LO);
		else
			sat_val = irar_pkg::SMP_W'(pre_sat);
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

>>> sv/integer_ratio_audio_resampler_core.sv
`timescale 1ns / 1ps
// Up mode: an input passes the queue, the command registers, s1 and the output register,
//   then gives n results (n = effective scale, 2..6), one per cycle while not stalled.
// Down mode: an input that closes a group gives one result via the 4-bit-per-cycle divider;
//   the back end takes the next command only after it returns to idle.
// Inputs that give no result push no command. Two queued commands decouple the sides.
// Reset: direction up, scale 2, one channel, all per-channel state zero, queue empty.
// ---------------------------------------------------------------------------
// integer_ratio_audio_resampler_core
// Integer-ratio audio resampler: linear interpolation up, block averaging down.
// ---------------------------------------------------------------------------
module integer_ratio_audio_resampler_core #(
	parameter int MAX_CHANNELS   = 2,
	parameter int MAX_DOWN_SCALE = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irar_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irar_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  irar_pkg::in_item_t               src_data,
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output irar_pkg::out_item_t              dst_data
);

	logic            q_full;
	logic            q_push;
	irar_pkg::cmd_t  q_push_data;
	logic            q_pop;
	logic            q_avail;
	irar_pkg::cmd_t  q_pop_data;

	irar_front #(
		.MAX_CHANNELS   (MAX_CHANNELS),
		.MAX_DOWN_SCALE (MAX_DOWN_SCALE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_data    (src_data),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_push_data (q_push_data)
	);

	irar_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_data  (q_pop_data)
	);

	irar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_avail),
		.cmd       (q_pop_data),
		.cmd_pop   (q_pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

>>> sv/irar_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irar_checker
// Port-level checks on the resampler output stream and reset behavior.
// ---------------------------------------------------------------------------
module irar_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 src_stall,
	input logic                 dst_valid,
	input logic                 dst_stall,
	input irar_pkg::out_item_t  dst_data
);

	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("output beat changed while stalled");

	// results of one input come back to back on the same channel
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_data.last_of_run |=>
			dst_valid && (dst_data.channel_out == $past(dst_data.channel_out)))
		else $error("run of results broken before its last beat");

	// right out of reset nothing is pending and the input is open
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !dst_valid && !src_stall)
		else $error("block not empty after reset");

endmodule

bind integer_ratio_audio_resampler_core irar_checker u_irar_checker (.*);
